// File: sv/mht_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and controller state encoding for the MAC address hash table.
package mht_pkg;

   localparam int SLOTS_DEFAULT = 256;

   localparam int MAC_W      = 48;
   localparam int CMD_W      = 3;
   localparam int SLOT_W     = 8;
   localparam int MISS_W     = 4;
   localparam int HASH_W     = 32;
   localparam int CHAR_W     = 8;
   localparam int HASH_CHARS = 17;
   localparam int CHAR_CNT_W = $clog2(HASH_CHARS);
   localparam int MOD_BITS   = 4;
   localparam int MOD_STEPS  = HASH_W / MOD_BITS;
   localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

   localparam logic [HASH_W-1:0] HASH_SEED      = 32'd5381;
   localparam logic [CHAR_W-1:0] CHAR_COLON     = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_OFS = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA_OFS = 8'h37;
   localparam logic [MISS_W-1:0] MISS_MAX       = 4'hF;
   localparam logic [MISS_W-1:0] MISS_THR_RESET = 4'd2;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_MISS_THRESHOLD = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP    = 3'd0,
      CMD_INSERT    = 3'd1,
      CMD_DELETE    = 3'd2,
      CMD_SEEN      = 3'd3,
      CMD_MISS      = 3'd4,
      CMD_CLEAR_ALL = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2
   } stat_type;

   typedef enum logic [1:0] {
      EV_NONE       = 2'd0,
      EV_CONNECT    = 2'd1,
      EV_DISCONNECT = 2'd2
   } ev_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_USED  = 2'd1,
      SLOT_TOMB  = 2'd2
   } slot_state_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [MAC_W-1:0] mac;
      logic             notify;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic [1:0]        status;
      logic [1:0]        event_res;
      logic [MISS_W-1:0] miss_count;
   } rsp_type;

   typedef struct packed {
      slot_state_type    state;
      logic [MISS_W-1:0] misses;
      logic [MAC_W-1:0]  key;
   } tbl_word_type;

   typedef enum logic [3:0] {
      ST_INIT_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_HASH,
      ST_MOD,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_UPDATE,
      ST_CLEAR_ALL,
      ST_RESPOND
   } fsm_state_type;

   typedef struct packed {
      logic load;
      logic hash_step;
      logic mod_step;
      logic probe_rd;
      logic probe_chk;
      logic update;
      logic clr_step;
      logic rsp_load;
   } ctl_type;

   typedef struct packed {
      logic cmd_clear;
      logic cmd_search;
      logic hash_last;
      logic mod_last;
      logic probe_stop;
      logic clr_last;
   } sts_type;

endpackage

// File: sv/mht_datapath.sv
`timescale 1ns / 1ps
// Datapath of the MAC address hash table: hash, slot reduction, probe and table memory.
module mht_datapath #(
   parameter int SLOTS = mht_pkg::SLOTS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mht_pkg::ctl_type            ctl,
   input  mht_pkg::req_type            req_payload,
   input  logic [mht_pkg::MISS_W-1:0]  miss_threshold,
   output mht_pkg::sts_type            sts,
   output mht_pkg::rsp_type            rsp_payload
);
   import mht_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SLOTS - 1);
   localparam logic [IDX_W:0]   SLOTS_EXT = (IDX_W + 1)'(SLOTS);

   typedef enum logic [1:0] {
      PH_HI,
      PH_LO,
      PH_COLON
   } char_phase_type;

   tbl_word_type table_mem [SLOTS];

   req_type             req_ff, req_in;
   logic [MAC_W-1:0]    mac_sh_ff, mac_sh_in;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   char_phase_type      phase_ff, phase_in;
   logic [CHAR_CNT_W-1:0] char_cnt_ff, char_cnt_in;
   logic [MOD_CNT_W-1:0]  mod_cnt_ff, mod_cnt_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    probe_cnt_ff, probe_cnt_in;
   logic                found_ff, found_in;
   logic [MISS_W-1:0]   miss_ff, miss_in;
   logic                free_v_ff, free_v_in;
   logic [IDX_W-1:0]    free_ff, free_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0]    clr_idx_ff, clr_idx_in;
   tbl_word_type        rd_word_ff;

   logic [3:0]          nibble;
   logic [CHAR_W-1:0]   char_code;
   logic [IDX_W-1:0]    mod_rem;
   logic [IDX_W:0]      mod_trial;
   logic [IDX_W-1:0]    idx_next;
   logic                probe_empty;
   logic                probe_used;
   logic                probe_match;
   logic                probe_stop;
   logic [MISS_W-1:0]   miss_inc;
   logic                removed;
   logic                upd_wr;
   logic [IDX_W-1:0]    upd_addr;
   tbl_word_type        upd_word;
   rsp_type             upd_res;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   tbl_word_type        wr_word;

   // Character generator for the text form of the address.
   assign nibble = mac_sh_ff[MAC_W-1 -: 4];

   always_comb begin
      if (phase_ff == PH_COLON) begin
         char_code = CHAR_COLON;
      end else if (nibble < 4'd10) begin
         char_code = CHAR_DIGIT_OFS + {4'b0, nibble};
      end else begin
         char_code = CHAR_ALPHA_OFS + {4'b0, nibble};
      end
   end

   // Reduction of the hash modulo the slot count, several bits per cycle.
   always_comb begin
      mod_rem   = idx_ff;
      mod_trial = '0;
      for (int j = 0; j < MOD_BITS; j++) begin
         mod_trial = {mod_rem, hash_ff[HASH_W-1-j]};
         if (mod_trial >= SLOTS_EXT) begin
            mod_trial = mod_trial - SLOTS_EXT;
         end
         mod_rem = mod_trial[IDX_W-1:0];
      end
   end

   assign idx_next    = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
   assign probe_empty = (rd_word_ff.state == SLOT_EMPTY);
   assign probe_used  = (rd_word_ff.state == SLOT_USED);
   assign probe_match = probe_used && (rd_word_ff.key == req_ff.mac);
   assign probe_stop  = probe_match || probe_empty || (probe_cnt_ff == IDX_LAST);

   // Table update and result for the searching commands.
   assign miss_inc = (miss_ff == MISS_MAX) ? MISS_MAX : miss_ff + 1'b1;
   assign removed  = (miss_inc >= miss_threshold);

   always_comb begin
      upd_wr              = 1'b0;
      upd_addr            = idx_ff;
      upd_word.state      = SLOT_USED;
      upd_word.misses     = '0;
      upd_word.key        = req_ff.mac;
      upd_res.found       = found_ff;
      upd_res.slot        = found_ff ? SLOT_W'(idx_ff) : '0;
      upd_res.status      = STAT_OK;
      upd_res.event_res   = EV_NONE;
      upd_res.miss_count  = found_ff ? miss_ff : '0;
      unique case (req_ff.command)
         CMD_LOOKUP: begin
            if (!found_ff) begin
               upd_res.status = STAT_NOT_FOUND;
            end
         end
         CMD_INSERT: begin
            if (!found_ff) begin
               if (!free_v_ff) begin
                  upd_res.status = STAT_FULL;
               end else begin
                  upd_wr             = 1'b1;
                  upd_addr           = free_ff;
                  upd_res.slot       = SLOT_W'(free_ff);
                  upd_res.miss_count = '0;
                  upd_res.event_res  = req_ff.notify ? EV_CONNECT : EV_NONE;
               end
            end
         end
         CMD_DELETE: begin
            if (!found_ff) begin
               upd_res.status = STAT_NOT_FOUND;
            end else begin
               upd_wr            = 1'b1;
               upd_word.state    = SLOT_TOMB;
               upd_word.misses   = miss_ff;
               upd_res.event_res = req_ff.notify ? EV_DISCONNECT : EV_NONE;
            end
         end
         CMD_SEEN: begin
            if (!found_ff) begin
               upd_res.status = STAT_NOT_FOUND;
            end else begin
               upd_wr             = 1'b1;
               upd_res.miss_count = '0;
            end
         end
         CMD_MISS: begin
            if (!found_ff) begin
               upd_res.status = STAT_NOT_FOUND;
            end else begin
               upd_wr             = 1'b1;
               upd_word.state     = removed ? SLOT_TOMB : SLOT_USED;
               upd_word.misses    = miss_inc;
               upd_res.miss_count = miss_inc;
               upd_res.event_res  = (removed && req_ff.notify) ? EV_DISCONNECT : EV_NONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = upd_addr;
      wr_word = upd_word;
      if (ctl.clr_step) begin
         wr_en         = 1'b1;
         wr_addr       = clr_idx_ff;
         wr_word.state = SLOT_EMPTY;
      end else if (ctl.update) begin
         wr_en = upd_wr;
      end
   end

   always_comb begin
      req_in       = req_ff;
      mac_sh_in    = mac_sh_ff;
      hash_in      = hash_ff;
      phase_in     = phase_ff;
      char_cnt_in  = char_cnt_ff;
      mod_cnt_in   = mod_cnt_ff;
      idx_in       = idx_ff;
      probe_cnt_in = probe_cnt_ff;
      found_in     = found_ff;
      miss_in      = miss_ff;
      free_v_in    = free_v_ff;
      free_in      = free_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      clr_idx_in   = clr_idx_ff;
      if (ctl.load) begin
         req_in       = req_payload;
         mac_sh_in    = req_payload.mac;
         hash_in      = HASH_SEED;
         phase_in     = PH_HI;
         char_cnt_in  = '0;
         mod_cnt_in   = '0;
         idx_in       = '0;
         probe_cnt_in = '0;
         found_in     = 1'b0;
         miss_in      = '0;
         free_v_in    = 1'b0;
         free_in      = '0;
         res_in       = '0;
      end
      if (ctl.hash_step) begin
         hash_in     = (hash_ff << 5) + hash_ff + HASH_W'(char_code);
         char_cnt_in = char_cnt_ff + 1'b1;
         unique case (phase_ff)
            PH_HI: begin
               phase_in  = PH_LO;
               mac_sh_in = mac_sh_ff << 4;
            end
            PH_LO: begin
               phase_in  = PH_COLON;
               mac_sh_in = mac_sh_ff << 4;
            end
            default: begin
               phase_in = PH_HI;
            end
         endcase
      end
      if (ctl.mod_step) begin
         idx_in     = mod_rem;
         hash_in    = hash_ff << MOD_BITS;
         mod_cnt_in = mod_cnt_ff + 1'b1;
      end
      if (ctl.probe_chk) begin
         if (probe_match) begin
            found_in = 1'b1;
            miss_in  = rd_word_ff.misses;
         end else if (!probe_used && !free_v_ff) begin
            free_v_in = 1'b1;
            free_in   = idx_ff;
         end
         if (!probe_stop) begin
            idx_in       = idx_next;
            probe_cnt_in = probe_cnt_ff + 1'b1;
         end
      end
      if (ctl.update) begin
         res_in = upd_res;
      end
      if (ctl.clr_step) begin
         clr_idx_in = (clr_idx_ff == IDX_LAST) ? '0 : clr_idx_ff + 1'b1;
      end
      if (ctl.rsp_load) begin
         rsp_data_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      mac_sh_ff    <= mac_sh_in;
      hash_ff      <= hash_in;
      phase_ff     <= phase_in;
      char_cnt_ff  <= char_cnt_in;
      mod_cnt_ff   <= mod_cnt_in;
      idx_ff       <= idx_in;
      probe_cnt_ff <= probe_cnt_in;
      found_ff     <= found_in;
      miss_ff      <= miss_in;
      free_v_ff    <= free_v_in;
      free_ff      <= free_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else begin
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.probe_rd) begin
         rd_word_ff <= table_mem[idx_ff];
      end
   end

   assign sts.cmd_clear  = (req_ff.command == CMD_CLEAR_ALL);
   assign sts.cmd_search = (req_ff.command <= CMD_MISS);
   assign sts.hash_last  = (char_cnt_ff == CHAR_CNT_W'(HASH_CHARS - 1));
   assign sts.mod_last   = (mod_cnt_ff == MOD_CNT_W'(MOD_STEPS - 1));
   assign sts.probe_stop = probe_stop;
   assign sts.clr_last   = (clr_idx_ff == IDX_LAST);

   assign rsp_payload = rsp_data_ff;

   a_probe_idx_range: assert property (@(posedge clock) disable iff (reset)
      ctl.probe_chk |-> ({1'b0, idx_ff} < SLOTS_EXT))
      else $error("probe index outside the table");

   a_empty_gives_free: assert property (@(posedge clock) disable iff (reset)
      ctl.probe_chk && probe_empty |=> free_v_ff)
      else $error("empty slot on the probe path was not recorded as free");

   a_match_holds_slot: assert property (@(posedge clock) disable iff (reset)
      ctl.probe_chk && probe_match |=> found_ff && (idx_ff == $past(idx_ff)))
      else $error("matching slot was not kept");

endmodule

// File: sv/mht_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the MAC address hash table.
module mht_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  mht_pkg::sts_type sts,
   output mht_pkg::ctl_type ctl
);
   import mht_pkg::*;

   fsm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT_CLEAR: begin
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            priority if (sts.cmd_clear) begin
               state_in = ST_CLEAR_ALL;
            end else if (sts.cmd_search) begin
               state_in = ST_HASH;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_HASH: begin
            if (sts.hash_last) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (sts.mod_last) begin
               state_in = ST_PROBE_RD;
            end
         end
         ST_PROBE_RD: begin
            state_in = ST_PROBE_CHK;
         end
         ST_PROBE_CHK: begin
            state_in = sts.probe_stop ? ST_UPDATE : ST_PROBE_RD;
         end
         ST_UPDATE: begin
            state_in = ST_RESPOND;
         end
         ST_CLEAR_ALL: begin
            if (sts.clr_last) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl           = '0;
      ctl.load      = (state_ff == ST_IDLE) && req_valid;
      ctl.hash_step = (state_ff == ST_HASH);
      ctl.mod_step  = (state_ff == ST_MOD);
      ctl.probe_rd  = (state_ff == ST_PROBE_RD);
      ctl.probe_chk = (state_ff == ST_PROBE_CHK);
      ctl.update    = (state_ff == ST_UPDATE);
      ctl.clr_step  = (state_ff == ST_INIT_CLEAR) || (state_ff == ST_CLEAR_ALL);
      ctl.rsp_load  = (state_ff == ST_RESPOND) && rsp_free;
      req_ready     = (state_ff == ST_IDLE);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_after_respond: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESPOND))
      else $error("result beat raised outside the respond step");

   a_one_item_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while an item is in progress");

endmodule

// File: sv/mac_address_hash_table.sv
`timescale 1ns / 1ps
// Top level of the MAC address hash table with its register port.
//
// Commands arrive as beats on the req_ channel (valid/ready); each produces one
// result beat on the rsp_ channel. One command is in progress at a time.
// A searching command (lookup, insert, delete, seen, miss) hashes the
// 17-character text of the address at one character per cycle, reduces the
// hash modulo SLOTS at four bits per cycle, then probes the table slot by slot
// through its single read port, each slot read and then checked in turn.
// clear_all sweeps the table one slot per cycle, then responds.
// After reset the same sweep runs with req_ready low.
// The result sits in an output register; the next command is accepted while
// it waits, and a finished result holds the block until the receiver takes
// the pending one. The csr_ port holds miss_threshold (reset 2) at address 0
// and may be written only while the block is idle.
module mac_address_hash_table #(
   parameter int SLOTS = mht_pkg::SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  mht_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output mht_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mht_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mht_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mht_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import mht_pkg::*;

   logic [MISS_W-1:0] thr_ff, thr_in;
   logic              csr_sel_thr;
   ctl_type           ctl;
   sts_type           sts;

   assign csr_pready  = 1'b1;
   assign csr_sel_thr = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_MISS_THRESHOLD);

   always_comb begin
      thr_in = thr_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_thr) begin
         thr_in = csr_pwdata[MISS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= MISS_THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign csr_prdata = csr_sel_thr ? CSR_DATA_W'(thr_ff) : '0;

   mht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   mht_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .req_payload    (req_payload),
      .miss_threshold (thr_ff),
      .sts            (sts),
      .rsp_payload    (rsp_payload)
   );

endmodule
